// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the checker files of the spin lattice block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is asserted.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds at a rising edge out of reset.
`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
  `CHK_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ----- hdl/ismsu_pkg.sv -----
// Types, constants and codes shared by the Ising spin update block.
package ismsu_pkg;

  // Lattice geometry
  localparam int SIDE_MAX   = 128;
  localparam int ROW_W      = $clog2(SIDE_MAX);
  localparam int SIDE_W     = $clog2(SIDE_MAX + 1);
  localparam int SIDE_REG_W = 8;
  localparam int CMP_W      = (SIDE_W > SIDE_REG_W) ? SIDE_W : SIDE_REG_W;

  // Field widths
  localparam int FUNC_W    = 2;
  localparam int COORD_W   = 7;
  localparam int RND_W     = 16;
  localparam int COUNT_W   = 15;
  localparam int THR_W     = 17;
  localparam int ACC_W     = 2 * THR_W;
  localparam int NUM_SUMS  = 5;
  localparam int SUM_W     = 3;
  localparam int CFG_IDX_W = 3;

  // Command queue between front and back
  localparam int QDEPTH   = 2;
  localparam int Q_PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int Q_CNT_W  = $clog2(QDEPTH + 1);

  // Items that can be in flight: queue plus one in the back end or result register
  localparam int MAX_PENDING = QDEPTH + 1;
  localparam int PEND_W      = $clog2(MAX_PENDING + 1);

  // Register reset values
  localparam logic [SIDE_REG_W-1:0] SIDE_RESET = SIDE_REG_W'(128);
  localparam logic [THR_W-1:0]      THR_ALWAYS = THR_W'(65536);
  localparam logic [ACC_W-1:0]      ACC_RESET  = {THR_ALWAYS, THR_ALWAYS};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SIDE,
    CFG_ACC_M4,
    CFG_ACC_M2,
    CFG_ACC_Z,
    CFG_ACC_P2,
    CFG_ACC_P4
  } cfg_idx_e;

  // Function codes on the input channel
  localparam logic [FUNC_W-1:0] FUNC_WRITE = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FUNC_READ  = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FUNC_STEP  = FUNC_W'(2);

  // Operation classes decided by the front end
  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_STEP,
    OP_ERROR
  } op_e;

  typedef logic [ROW_W-1:0] idx_t;

  typedef struct packed {
    op_e              op;
    idx_t             row;
    idx_t             row_up;
    idx_t             row_dn;
    idx_t             col;
    idx_t             col_lf;
    idx_t             col_rt;
    logic             spin_value;
    logic [RND_W-1:0] random_value;
  } cmd_t;

  typedef struct packed {
    logic [SIDE_REG_W-1:0]          side;
    logic [NUM_SUMS-1:0][ACC_W-1:0] acc;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CTR,
    ST_UP,
    ST_DN
  } back_state_e;

endpackage

// ----- hdl/ismsu_if.sv -----
// Valid/ready channel interfaces for the spin update input and result.
interface ismsu_in_if;
  import ismsu_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic               spin_value;
  logic [RND_W-1:0]   random_value;

  modport source (output valid, func, row, col, spin_value, random_value, input ready);
  modport sink   (input valid, func, row, col, spin_value, random_value, output ready);
endinterface

interface ismsu_out_if;
  import ismsu_pkg::*;

  logic               valid;
  logic               ready;
  logic               spin_now;
  logic               flipped;
  logic [COUNT_W-1:0] up_count;
  logic               coord_error;

  modport source (output valid, spin_now, flipped, up_count, coord_error, input ready);
  modport sink   (input valid, spin_now, flipped, up_count, coord_error, output ready);
endinterface

// ----- hdl/ismsu_front.sv -----
// Front end: accepts input transactions, checks coordinates, computes wrapped neighbors.
module ismsu_front (
  ismsu_in_if.sink                        in_ch,
  input  logic [ismsu_pkg::SIDE_REG_W-1:0] side_i,
  input  logic                            back_ready_i,
  input  logic                            q_full_i,
  output logic                            push_o,
  output ismsu_pkg::cmd_t                 cmd_o
);
  import ismsu_pkg::*;

  logic [CMP_W-1:0] side_ext;
  logic [CMP_W-1:0] max_ext;
  logic [CMP_W-1:0] side;
  logic [CMP_W-1:0] row_ext;
  logic [CMP_W-1:0] col_ext;
  logic [CMP_W-1:0] row_up;
  logic [CMP_W-1:0] row_dn;
  logic [CMP_W-1:0] col_lf;
  logic [CMP_W-1:0] col_rt;
  logic             coord_err;

  // Accept only once the lattice is cleared and the queue has room
  assign in_ch.ready = back_ready_i && !q_full_i;
  assign push_o      = in_ch.valid && in_ch.ready;

  // Saturate the side to the lattice size
  assign side_ext = CMP_W'(side_i);
  assign max_ext  = CMP_W'(SIDE_MAX);
  assign side     = (side_ext > max_ext) ? max_ext : side_ext;

  assign row_ext   = CMP_W'(in_ch.row);
  assign col_ext   = CMP_W'(in_ch.col);
  assign coord_err = (row_ext >= side) || (col_ext >= side);

  // Periodic wrap of the four neighbors
  assign row_up = (row_ext == '0) ? side - CMP_W'(1) : row_ext - CMP_W'(1);
  assign row_dn = (row_ext + CMP_W'(1) == side) ? '0 : row_ext + CMP_W'(1);
  assign col_lf = (col_ext == '0) ? side - CMP_W'(1) : col_ext - CMP_W'(1);
  assign col_rt = (col_ext + CMP_W'(1) == side) ? '0 : col_ext + CMP_W'(1);

  // Classify the transaction and pack the command
  always_comb begin
    cmd_o.row          = ROW_W'(in_ch.row);
    cmd_o.col          = ROW_W'(in_ch.col);
    cmd_o.row_up       = ROW_W'(row_up);
    cmd_o.row_dn       = ROW_W'(row_dn);
    cmd_o.col_lf       = ROW_W'(col_lf);
    cmd_o.col_rt       = ROW_W'(col_rt);
    cmd_o.spin_value   = in_ch.spin_value;
    cmd_o.random_value = in_ch.random_value;
    case (in_ch.func)
      FUNC_WRITE: cmd_o.op = OP_WRITE;
      FUNC_STEP:  cmd_o.op = OP_STEP;
      default:    cmd_o.op = OP_READ;
    endcase
    if (coord_err) begin
      cmd_o.op = OP_ERROR;
    end
  end

endmodule

// ----- hdl/ismsu_queue.sv -----
// Short command queue that decouples the front end from the lattice sequencer.
module ismsu_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ismsu_pkg::cmd_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output ismsu_pkg::cmd_t head_o,
  output logic            valid_o
);
  import ismsu_pkg::*;

  cmd_t               slot_q [QDEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == Q_CNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Advance pointers and the fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + Q_PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + Q_PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + Q_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/ismsu_back.sv -----
// Back end: lattice row memory, up-spin counter, update sequencer and result register.
module ismsu_back (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic [ismsu_pkg::NUM_SUMS-1:0][ismsu_pkg::ACC_W-1:0]  acc_i,
  input  ismsu_pkg::cmd_t                                       head_i,
  input  logic                                                  q_valid_i,
  output logic                                                  pop_o,
  output logic                                                  ready_o,
  ismsu_out_if.source                                           out_ch
);
  import ismsu_pkg::*;

  back_state_e state_q, state_d;
  idx_t        clr_q, clr_d;
  cmd_t        cmd_q, cmd_d;
  logic [SIDE_MAX-1:0] row_q, row_d;
  logic                up_bit_q, up_bit_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;

  // Result register
  logic               out_valid_q, out_valid_d;
  logic               spin_q, spin_d;
  logic               flip_q, flip_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               err_q, err_d;

  // Lattice memory, one row per word
  logic [SIDE_MAX-1:0] mem [SIDE_MAX];
  logic [SIDE_MAX-1:0] rd_q;
  logic                mem_we;
  idx_t                mem_waddr;
  logic [SIDE_MAX-1:0] mem_wdata;
  logic                mem_re;
  idx_t                mem_raddr;

  // Step evaluation
  logic             out_free;
  logic             ctr_bit;
  logic             dn_bit;
  logic [SUM_W-1:0] n_up;
  logic [ACC_W-1:0] acc_pair;
  logic [THR_W-1:0] thr;
  logic             do_flip;

  assign out_free = !out_valid_q || out_ch.ready;
  assign ready_o  = (state_q != ST_CLEAR);

  assign out_ch.valid       = out_valid_q;
  assign out_ch.spin_now    = spin_q;
  assign out_ch.flipped     = flip_q;
  assign out_ch.up_count    = count_q;
  assign out_ch.coord_error = err_q;

  // Neighbor sum and acceptance test in the last read cycle of a step
  assign ctr_bit  = row_q[cmd_q.col];
  assign dn_bit   = rd_q[cmd_q.col];
  assign n_up     = SUM_W'(up_bit_q) + SUM_W'(dn_bit) + SUM_W'(row_q[cmd_q.col_lf])
                  + SUM_W'(row_q[cmd_q.col_rt]);
  assign acc_pair = acc_i[n_up];
  assign thr      = ctr_bit ? acc_pair[ACC_W-1:THR_W] : acc_pair[THR_W-1:0];
  assign do_flip  = ({1'b0, cmd_q.random_value} < thr);

  // Sequence memory accesses and build results
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    cmd_d       = cmd_q;
    row_d       = row_q;
    up_bit_d    = up_bit_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    spin_d      = spin_q;
    flip_d      = flip_q;
    count_d     = count_q;
    err_d       = err_q;
    mem_we      = 1'b0;
    mem_waddr   = cmd_q.row;
    mem_wdata   = rd_q;
    mem_re      = 1'b0;
    mem_raddr   = cmd_q.row;
    pop_o       = 1'b0;

    // Drop the result once taken
    if (out_valid_q && out_ch.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == ROW_W'(SIDE_MAX - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + ROW_W'(1);
        end
      end
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          pop_o = 1'b1;
          cmd_d = head_i;
          if (head_i.op == OP_ERROR) begin
            out_valid_d = 1'b1;
            spin_d      = 1'b0;
            flip_d      = 1'b0;
            count_d     = cnt_q;
            err_d       = 1'b1;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = head_i.row;
            state_d   = ST_CTR;
          end
        end
      end
      ST_CTR: begin
        case (cmd_q.op)
          OP_WRITE: begin
            mem_we                = 1'b1;
            mem_wdata             = rd_q;
            mem_wdata[cmd_q.col]  = cmd_q.spin_value;
            if (rd_q[cmd_q.col] != cmd_q.spin_value) begin
              cnt_d = cmd_q.spin_value ? cnt_q + COUNT_W'(1) : cnt_q - COUNT_W'(1);
            end
            out_valid_d = 1'b1;
            spin_d      = cmd_q.spin_value;
            flip_d      = 1'b0;
            count_d     = cnt_d;
            err_d       = 1'b0;
            state_d     = ST_IDLE;
          end
          OP_STEP: begin
            row_d     = rd_q;
            mem_re    = 1'b1;
            mem_raddr = cmd_q.row_up;
            state_d   = ST_UP;
          end
          default: begin
            out_valid_d = 1'b1;
            spin_d      = rd_q[cmd_q.col];
            flip_d      = 1'b0;
            count_d     = cnt_q;
            err_d       = 1'b0;
            state_d     = ST_IDLE;
          end
        endcase
      end
      ST_UP: begin
        up_bit_d  = rd_q[cmd_q.col];
        mem_re    = 1'b1;
        mem_raddr = cmd_q.row_dn;
        state_d   = ST_DN;
      end
      ST_DN: begin
        mem_wdata            = row_q;
        mem_wdata[cmd_q.col] = !ctr_bit;
        if (do_flip) begin
          mem_we = 1'b1;
          cnt_d  = ctr_bit ? cnt_q - COUNT_W'(1) : cnt_q + COUNT_W'(1);
        end
        out_valid_d = 1'b1;
        spin_d      = ctr_bit ^ do_flip;
        flip_d      = do_flip;
        count_d     = cnt_d;
        err_d       = 1'b0;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    row_q    <= row_d;
    up_bit_q <= up_bit_d;
    spin_q   <= spin_d;
    flip_q   <= flip_d;
    count_q  <= count_d;
    err_q    <= err_d;
  end

  // Lattice memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

endmodule

// ----- hdl/ising_metropolis_spin_update_top.sv -----
// Top level of the 2-D Ising lattice with Metropolis single-spin-flip updates.
// Holds a SIDE_MAX x SIDE_MAX lattice of one-bit spins (1 = +1) with periodic wrap at the
// configured side, plus a count of up spins. Input transactions write, read or Metropolis-step
// one site; each gives exactly one result. After reset a clearing pass writes every lattice row
// to -1 with the input channel not ready; configuration writes are taken as usual. Input
// transactions enter a two-entry command queue after the front end's coordinate check. The
// back end uses a row-wide memory with one read and one write port: a step reads the centre,
// upper and lower rows in turn and writes the row back if the spin flips; a read or write
// reads the row once, and an out-of-range site needs no memory access. The back end starts an
// item only when the result register is empty or being taken in that cycle. Configuration is
// to be written only while the block is idle; the block itself does not enforce this.
module ising_metropolis_spin_update_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ismsu_in_if.sink                         in_ch_i,
  ismsu_out_if.source                      out_ch_o,
  input  logic                             cfg_we_i,
  input  logic [ismsu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ismsu_pkg::ACC_W-1:0]      cfg_wdata_i
);
  import ismsu_pkg::*;

  cfg_t cfg_q;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  cmd_t head;
  logic q_valid;
  logic back_ready;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.side <= SIDE_RESET;
      for (int i = 0; i < NUM_SUMS; i++) begin
        cfg_q.acc[i] <= ACC_RESET;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SIDE:   cfg_q.side   <= cfg_wdata_i[SIDE_REG_W-1:0];
        CFG_ACC_M4: cfg_q.acc[0] <= cfg_wdata_i;
        CFG_ACC_M2: cfg_q.acc[1] <= cfg_wdata_i;
        CFG_ACC_Z:  cfg_q.acc[2] <= cfg_wdata_i;
        CFG_ACC_P2: cfg_q.acc[3] <= cfg_wdata_i;
        CFG_ACC_P4: cfg_q.acc[4] <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  ismsu_front u_front (
    .in_ch        (in_ch_i),
    .side_i       (cfg_q.side),
    .back_ready_i (back_ready),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (push_cmd)
  );

  ismsu_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .head_o      (head),
    .valid_o     (q_valid)
  );

  ismsu_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (cfg_q.acc),
    .head_i    (head),
    .q_valid_i (q_valid),
    .pop_o     (pop),
    .ready_o   (back_ready),
    .out_ch    (out_ch_o)
  );

endmodule

// ----- hdl/ismsu_checker.sv -----
// Port-level checker for the spin update top level, with its bind statement.
`include "assert_macros.svh"

module ismsu_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic                            spin_now_i,
  input logic                            flipped_i,
  input logic [ismsu_pkg::COUNT_W-1:0]   up_count_i,
  input logic                            coord_error_i
);
  import ismsu_pkg::*;

  logic              in_acc;
  logic              out_acc;
  logic [PEND_W-1:0] pend_q, pend_d;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // Track transactions accepted but not yet answered
  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + PEND_W'(1);
    end else if (out_acc && !in_acc) begin
      pend_d = pend_q - PEND_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // Hold a stalled result
  `CHK_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(spin_now_i) && $stable(flipped_i) && $stable(up_count_i) && $stable(coord_error_i), "stalled result changed")

  // A result only answers an accepted transaction
  `CHK_NEVER(a_no_orphan, clk_i, rst_ni, out_valid_i && pend_q == '0, "result without pending transaction")

  // Back-pressure once every slot is taken
  `CHK_NEVER(a_full_stall, clk_i, rst_ni, pend_q == PEND_W'(MAX_PENDING) && in_ready_i, "input ready with all slots in use")

endmodule

bind ising_metropolis_spin_update_top ismsu_checker u_ismsu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_ch_i.valid),
  .in_ready_i    (in_ch_i.ready),
  .out_valid_i   (out_ch_o.valid),
  .out_ready_i   (out_ch_o.ready),
  .spin_now_i    (out_ch_o.spin_now),
  .flipped_i     (out_ch_o.flipped),
  .up_count_i    (out_ch_o.up_count),
  .coord_error_i (out_ch_o.coord_error)
);

// ----- verif/tb_top.sv -----
// Self-checking testbench for the Ising lattice Metropolis spin update block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ismsu_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = FUNC_W'(3);
  localparam int RAND_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int LONG_HOLD       = 300;
  localparam logic [THR_W-1:0] THR_MAX = '1;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               spin_value;
    logic [RND_W-1:0]   random_value;
  } spin_op_t;

  typedef struct {
    logic               spin_now;
    logic               flipped;
    logic [COUNT_W-1:0] up_count;
    logic               coord_error;
  } spin_res_t;

  // Lattice model: tracks spins, up count and settings, and queues the
  // expected result of every accepted transaction.
  class spin_lattice_model;
    bit                  lattice [SIDE_MAX][SIDE_MAX];
    logic [COUNT_W-1:0]  up_total;
    logic [SIDE_REG_W-1:0] side_reg;
    logic [ACC_W-1:0]    accept_thr [NUM_SUMS];
    spin_res_t           expected_results [$];
    int                  fail_count;

    function new();
      up_total   = '0;
      side_reg   = SIDE_RESET;
      fail_count = 0;
      foreach (accept_thr[k]) accept_thr[k] = ACC_RESET;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [ACC_W-1:0] data);
      if (idx == CFG_SIDE) begin
        side_reg = data[SIDE_REG_W-1:0];
      end else begin
        accept_thr[int'(idx) - int'(CFG_ACC_M4)] = data;
      end
    endfunction

    function void set_spin(int r, int c, bit v);
      if (lattice[r][c] != v) begin
        if (v) up_total = up_total + 1'b1;
        else   up_total = up_total - 1'b1;
        lattice[r][c] = v;
      end
    endfunction

    // Apply one transaction to the lattice and queue its result.
    function void note_item(spin_op_t op);
      spin_res_t        res;
      int               side, r, c, up_r, dn_r, lf_c, rt_c, nsum;
      bit               centre;
      logic [THR_W-1:0] thr;
      side = (side_reg > SIDE_MAX) ? SIDE_MAX : int'(side_reg);
      r    = int'(op.row);
      c    = int'(op.col);
      res.spin_now    = 1'b0;
      res.flipped     = 1'b0;
      res.coord_error = 1'b0;
      if (r >= side || c >= side) begin
        res.coord_error = 1'b1;
      end else if (op.func == FUNC_WRITE) begin
        set_spin(r, c, op.spin_value);
        res.spin_now = op.spin_value;
      end else if (op.func == FUNC_STEP) begin
        // wrap neighbours at the active side
        up_r = (r == 0) ? side - 1 : r - 1;
        dn_r = (r + 1 == side) ? 0 : r + 1;
        lf_c = (c == 0) ? side - 1 : c - 1;
        rt_c = (c + 1 == side) ? 0 : c + 1;
        nsum = lattice[up_r][c] + lattice[dn_r][c] + lattice[r][lf_c] + lattice[r][rt_c];
        centre = lattice[r][c];
        thr = centre ? accept_thr[nsum][ACC_W-1:THR_W] : accept_thr[nsum][THR_W-1:0];
        if ({1'b0, op.random_value} < thr) begin
          res.flipped = 1'b1;
          set_spin(r, c, !centre);
        end
        res.spin_now = lattice[r][c];
      end else begin
        res.spin_now = lattice[r][c];
      end
      res.up_count = up_total;
      expected_results.insert(expected_results.size(), res);
    endfunction

    function void check_result(spin_res_t got);
      spin_res_t want;
      if (expected_results.size() == 0) begin
        $error("result with no transaction outstanding: spin_now=%0d flipped=%0d up_count=%0d",
               got.spin_now, got.flipped, got.up_count);
        fail_count++;
        return;
      end
      want = expected_results.pop_front();
      if (got.spin_now !== want.spin_now) begin
        $error("spin_now: expected %0d, actual %0d", want.spin_now, got.spin_now);
        fail_count++;
      end
      if (got.flipped !== want.flipped) begin
        $error("flipped: expected %0d, actual %0d", want.flipped, got.flipped);
        fail_count++;
      end
      if (got.up_count !== want.up_count) begin
        $error("up_count: expected %0d, actual %0d", want.up_count, got.up_count);
        fail_count++;
      end
      if (got.coord_error !== want.coord_error) begin
        $error("coord_error: expected %0d, actual %0d", want.coord_error, got.coord_error);
        fail_count++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [ACC_W-1:0]     cfg_wdata_i;

  ismsu_in_if  in_ch ();
  ismsu_out_if out_ch ();

  spin_lattice_model model = new();

  // Settings the stimulus is running under
  logic [SIDE_REG_W-1:0] cur_side;
  logic [ACC_W-1:0]      cur_thr [NUM_SUMS];
  bit src_idle_on;
  bit snk_idle_on;
  bit sink_hold_req;

  ising_metropolis_spin_update_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch_i     (in_ch),
    .out_ch_o    (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // Result side: check each transaction, stall in random bursts, and hold
  // off for a long stretch on request.
  initial begin
    int        stall_left;
    int        hold_left;
    bit        nxt_ready;
    spin_res_t got;
    stall_left = 0;
    hold_left  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        got.spin_now    = out_ch.spin_now;
        got.flipped     = out_ch.flipped;
        got.up_count    = out_ch.up_count;
        got.coord_error = out_ch.coord_error;
        model.check_result(got);
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        hold_left     = LONG_HOLD - 1;
        nxt_ready     = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6) - 1;
        nxt_ready  = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ch.ready <= nxt_ready;
    end
  end

  // Offer one transaction, with an optional idle burst first, and record it
  // once accepted.
  task automatic send_item(spin_op_t op);
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= op.func;
    in_ch.row          <= op.row;
    in_ch.col          <= op.col;
    in_ch.spin_value   <= op.spin_value;
    in_ch.random_value <= op.random_value;
    do @(posedge clk_i); while (!in_ch.ready);
    model.note_item(op);
  endtask

  task automatic send(logic [FUNC_W-1:0] func, int row, int col, int sv, int rnd);
    spin_op_t op;
    op.func         = func;
    op.row          = COORD_W'(row);
    op.col          = COORD_W'(col);
    op.spin_value   = 1'(sv);
    op.random_value = RND_W'(rnd);
    send_item(op);
  endtask

  // Drop valid and drain every outstanding result.
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
  endtask

  // Write all six registers from the current settings.
  task automatic apply_settings();
    cfg_idx_e idx;
    idx = CFG_SIDE;
    repeat (NUM_SUMS + 1) begin
      cfg_we_i  <= 1'b1;
      cfg_idx_i <= idx;
      if (idx == CFG_SIDE) cfg_wdata_i <= ACC_W'(cur_side);
      else                 cfg_wdata_i <= cur_thr[int'(idx) - int'(CFG_ACC_M4)];
      @(posedge clk_i);
      model.write_reg(idx, (idx == CFG_SIDE) ? ACC_W'(cur_side)
                                             : cur_thr[int'(idx) - int'(CFG_ACC_M4)]);
      idx = idx.next();
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all_thr(logic [THR_W-1:0] dn_thr, logic [THR_W-1:0] up_thr);
    foreach (cur_thr[k]) cur_thr[k] = {up_thr, dn_thr};
  endtask

  function automatic logic [THR_W-1:0] pick_thr();
    case ($urandom_range(0, 7))
      0: return '0;
      1, 2: return THR_ALWAYS;
      3: return THR_MAX;
      4: return THR_W'(1);
      5: return THR_W'(65535);
      default: return THR_W'($urandom_range(0, 131071));
    endcase
  endfunction

  function automatic logic [SIDE_REG_W-1:0] pick_side();
    case ($urandom_range(0, 11))
      0: return SIDE_REG_W'(2);
      1: return SIDE_REG_W'(3);
      2: return SIDE_REG_W'(4);
      3, 4: return SIDE_REG_W'($urandom_range(5, 8));
      5: return SIDE_REG_W'(16);
      6: return SIDE_REG_W'(SIDE_MAX);
      7: return SIDE_REG_W'($urandom_range(SIDE_MAX + 1, 255));
      8: return SIDE_REG_W'(1);
      9: return SIDE_REG_W'(0);
      10: return SIDE_REG_W'(SIDE_MAX - 1);
      default: return SIDE_REG_W'($urandom_range(2, SIDE_MAX));
    endcase
  endfunction

  // Build a random transaction, mostly on the active square, with random
  // values biased to the edges and to the current thresholds.
  function automatic spin_op_t make_item();
    spin_op_t         op;
    int               side, sel;
    logic [ACC_W-1:0] t;
    logic [THR_W-1:0] h;
    side = (cur_side > SIDE_MAX) ? SIDE_MAX : int'(cur_side);
    sel  = $urandom_range(0, 19);
    if (sel < 12)      op.func = FUNC_STEP;
    else if (sel < 16) op.func = FUNC_WRITE;
    else if (sel < 19) op.func = FUNC_READ;
    else               op.func = FUNC_SPARE;
    if (side > 0 && (side == SIDE_MAX || $urandom_range(0, 9) != 0)) begin
      op.row = COORD_W'($urandom_range(0, side - 1));
      op.col = COORD_W'($urandom_range(0, side - 1));
    end else if (side == 0) begin
      op.row = COORD_W'($urandom_range(0, SIDE_MAX - 1));
      op.col = COORD_W'($urandom_range(0, SIDE_MAX - 1));
    end else begin
      // push the row, the column or both off the active square
      op.row = COORD_W'($urandom_range(0, SIDE_MAX - 1));
      op.col = COORD_W'($urandom_range(0, SIDE_MAX - 1));
      sel = $urandom_range(0, 2);
      if (sel != 1) op.row = COORD_W'($urandom_range(side, SIDE_MAX - 1));
      if (sel != 0) op.col = COORD_W'($urandom_range(side, SIDE_MAX - 1));
    end
    op.spin_value = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0: op.random_value = '0;
      1: op.random_value = '1;
      2, 3: begin
        t = cur_thr[$urandom_range(0, NUM_SUMS - 1)];
        h = $urandom_range(0, 1) ? t[ACC_W-1:THR_W] : t[THR_W-1:0];
        op.random_value = h[RND_W-1:0] - RND_W'($urandom_range(0, 1));
      end
      default: op.random_value = RND_W'($urandom_range(0, 65535));
    endcase
    return op;
  endfunction

  // Main sequence: reset, directed cases, then random phases
  initial begin
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_idx_i          <= CFG_SIDE;
    cfg_wdata_i        <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.func         <= FUNC_READ;
    in_ch.row          <= '0;
    in_ch.col          <= '0;
    in_ch.spin_value   <= 1'b0;
    in_ch.random_value <= '0;
    src_idle_on   = 1'b1;
    snk_idle_on   = 1'b1;
    sink_hold_req = 1'b0;
    cur_side      = SIDE_RESET;
    set_all_thr(THR_ALWAYS, THR_ALWAYS);
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: cleared lattice, corner wrap, always-flip thresholds
    send(FUNC_READ, 0, 0, 0, 0);
    send(FUNC_WRITE, 127, 127, 1, 0);
    send(FUNC_WRITE, 0, 0, 1, 0);
    send(FUNC_WRITE, 0, 0, 1, 0);
    send(FUNC_SPARE, 127, 127, 0, 0);
    send(FUNC_STEP, 0, 0, 0, 65535);
    send(FUNC_STEP, 0, 127, 1, 0);
    send(FUNC_WRITE, 0, 127, 0, 0);
    finish_phase();

    // Side zero: every site is off the lattice
    cur_side = '0;
    apply_settings();
    send(FUNC_READ, 0, 0, 0, 0);
    send(FUNC_STEP, 127, 127, 0, 0);
    finish_phase();

    // Side one: the site is its own neighbour; extreme thresholds
    cur_side = SIDE_REG_W'(1);
    set_all_thr(THR_ALWAYS, THR_ALWAYS);
    cur_thr[0] = {17'd0, THR_MAX};
    cur_thr[NUM_SUMS-1] = {17'd0, THR_MAX};
    apply_settings();
    send(FUNC_WRITE, 0, 0, 0, 0);
    send(FUNC_STEP, 0, 0, 0, 65535);
    send(FUNC_STEP, 0, 0, 0, 0);
    send(FUNC_STEP, 0, 0, 0, 0);
    send(FUNC_STEP, 1, 0, 0, 0);
    send(FUNC_READ, 0, 1, 0, 0);
    finish_phase();

    // Oversized side saturates; zero thresholds never flip
    cur_side = SIDE_REG_W'(255);
    set_all_thr('0, '0);
    apply_settings();
    send(FUNC_STEP, 127, 0, 0, 0);
    send(FUNC_READ, 127, 127, 0, 0);
    finish_phase();

    // Side three: compare boundary at one below the threshold
    cur_side = SIDE_REG_W'(3);
    set_all_thr(THR_W'(65535), THR_W'(65535));
    apply_settings();
    send(FUNC_STEP, 2, 2, 0, 65535);
    send(FUNC_STEP, 2, 2, 0, 65534);
    send(FUNC_WRITE, 1, 1, 1, 0);
    send(FUNC_STEP, 3, 0, 0, 0);
    send(FUNC_WRITE, 0, 3, 1, 0);
    finish_phase();

    // Random phases, each under new settings
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0)      cur_side = SIDE_REG_W'(2);
      else if (ph == 1) cur_side = SIDE_REG_W'(SIDE_MAX);
      else if (ph == 2) cur_side = SIDE_REG_W'(8);
      else              cur_side = pick_side();
      foreach (cur_thr[k]) cur_thr[k] = {pick_thr(), pick_thr()};
      if (ph == RAND_PHASES - 1) begin
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
      end else begin
        src_idle_on = ($urandom_range(0, 4) != 0);
        snk_idle_on = ($urandom_range(0, 4) != 0);
      end
      apply_settings();
      if (ph == 1 || ph == 7) sink_hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_item(make_item());
      finish_phase();
    end

    // Catch any stray result after the drain
    repeat (20) @(posedge clk_i);
    if (model.fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
